// ===== rtl/uhj_pkg.sv =====
`default_nettype none

package uhj_pkg;

    // Fixed sample and coefficient formats.
    localparam int SAMPLE_BITS  = 24;
    localparam int COEFF_BITS   = 24;
    localparam int TAPS_DEFAULT = 128;

    localparam int FRAC     = COEFF_BITS - 1;
    localparam int FIR_DROP = 8;
    localparam int CSHIFT   = 32 - COEFF_BITS;

    // Mixing constants, Q31 values rounded half up to the coefficient grid.
    localparam logic signed [COEFF_BITS-1:0] K_MID_W =
        COEFF_BITS'((64'sd2017974493 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT);
    localparam logic signed [COEFF_BITS-1:0] K_MID_X =
        COEFF_BITS'((64'sd398517130 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT);
    localparam logic signed [COEFF_BITS-1:0] K_SIDE_Y =
        COEFF_BITS'((64'sd1407571593 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT);
    localparam logic signed [COEFF_BITS-1:0] K_SH_W_NEG =
        COEFF_BITS'(-((64'sd734482572 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT));
    localparam logic signed [COEFF_BITS-1:0] K_SH_X =
        COEFF_BITS'((64'sd1094916872 + (64'sd1 <<< (CSHIFT - 1))) >>> CSHIFT);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] w_sample;
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
        logic signed [SAMPLE_BITS-1:0] direct_left;
        logic signed [SAMPLE_BITS-1:0] direct_right;
    } uhj_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } uhj_out_t;

    // Restoring long division, evaluated only on constants when the
    // coefficient table is built.
    function automatic logic [63:0] uhj_udiv(input logic [63:0] num,
                                             input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q30 Taylor sine and cosine; returns {sin, cos}, each clamped at zero.
    function automatic logic [127:0] uhj_sincos(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic [63:0]        s;
        logic [63:0]        c;
        x2 = (x * x) >> 30;
        ts = x;
        tc = Q30_ONE;
        ss = $signed(x);
        cs = $signed(Q30_ONE);
        for (int k = 1; k <= 15; k++) begin
            tc = uhj_udiv((tc * x2) >> 30, 64'(2 * k - 1) * 64'(2 * k));
            ts = uhj_udiv((ts * x2) >> 30, 64'(2 * k) * 64'(2 * k + 1));
            if ((k % 2) == 1) begin
                cs = cs - $signed(tc);
                ss = ss - $signed(ts);
            end else begin
                cs = cs + $signed(tc);
                ss = ss + $signed(ts);
            end
        end
        s = (ss > 0) ? $unsigned(ss) : 64'd0;
        c = (cs > 0) ? $unsigned(cs) : 64'd0;
        return {s, c};
    endfunction

    // Coefficient of tap j of the wide-band +90 degree phase-shift FIR.
    function automatic logic signed [COEFF_BITS-1:0] uhj_coef(input int j,
                                                              input int taps);
        int           m;
        logic [63:0]  am;
        logic [63:0]  arg;
        logic [127:0] sc;
        logic [63:0]  den;
        logic [63:0]  mag;
        m = taps - 1 - 2 * j;
        if ((m % 2) == 0) begin
            return '0;
        end
        am  = 64'((m < 0) ? -m : m);
        arg = uhj_udiv(PI_Q30 * am, 64'(2 * taps));
        sc  = uhj_sincos(arg);
        den = 64'(taps) * sc[127:64];
        mag = (den == 64'd0) ? 64'd0 : uhj_udiv((sc[63:0] << FRAC) + (den >> 1), den);
        return (m > 0) ? COEFF_BITS'(64'd0 - mag) : COEFF_BITS'(mag);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uhj_ram.sv =====
`default_nettype none

module uhj_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uhj_two_channel_encoder.sv =====
`default_nettype none

// UHJ two-channel encoder. Each input transfer on s_data carries one B-format
// sample (W, X, Y) and a direct left/right pair; each output transfer on
// m_data carries one encoded left/right pair, saturated to Q1.23.
// Both channels use valid/ready. The block works on one item at a time: an
// item is taken while s_ready is high, runs five mixing products and then
// one FIR tap per clock through a single shared multiplier, and its result
// then appears on m_valid. The tap loop is bound by the one read port of
// the history memory and by the one multiplier.
// After reset the block sweeps both memories to zero, one address per
// cycle, and s_ready stays low during that sweep.
// A finished result sits in an output register. While the receiver stalls,
// the next item is still taken and processed, and it waits in its final
// step until the output register has been emptied.
module uhj_two_channel_encoder
    import uhj_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire uhj_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output uhj_out_t      m_data
);

    // Widths and depths that follow from the tap count.
    localparam int DLY_AW     = $clog2(TAPS);
    localparam int HIST_DEPTH = 2 * TAPS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int DL_W       = SAMPLE_BITS + 2;
    localparam int PROD_W     = SAMPLE_BITS + COEFF_BITS;
    localparam int MIX_W      = PROD_W + 1;
    localparam int FIR_W      = PROD_W - FIR_DROP + $clog2(TAPS) + 1;
    localparam int FIR_SH     = FRAC - FIR_DROP;
    localparam int SUM_W      = FIR_W + 2;

    localparam logic signed [MIX_W-1:0] MIX_HALF = MIX_W'(1) <<< (FRAC - 1);
    localparam logic signed [FIR_W-1:0] FIR_HALF = FIR_W'(1) <<< (FIR_SH - 1);
    localparam logic signed [SUM_W-1:0] OUT_MAX  = (SUM_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [SUM_W-1:0] OUT_MIN  = -(SUM_W'(1) <<< (SAMPLE_BITS - 1));

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_FIR,
        ST_DRAIN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MIX_MID_W,
        MIX_MID_X,
        MIX_SIDE_Y,
        MIX_SH_W,
        MIX_SH_X
    } mix_step_t;

    // Destination of a product as it leaves the multiplier register.
    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_MID,
        TAG_SIDE,
        TAG_SHIFT,
        TAG_FIR
    } tag_t;

    // Coefficient ROM, built from constants at elaboration.
    logic signed [COEFF_BITS-1:0] coef_rom [TAPS];

    for (genvar g = 0; g < TAPS; g++) begin : g_rom
        assign coef_rom[g] = uhj_coef(g, TAPS);
    end

    state_t                        state_reg;
    state_t                        state_next;
    mix_step_t                     mix_step_reg;
    mix_step_t                     mix_step_next;
    logic [HIST_AW-1:0]            clr_reg;
    logic [DLY_AW-1:0]             p_reg;
    logic [HIST_AW-1:0]            wp_reg;
    logic [HIST_AW-1:0]            hist_addr_reg;
    logic [DLY_AW-1:0]             j_reg;
    logic                          drain_reg;
    uhj_in_t                       in_reg;
    logic signed [SAMPLE_BITS-1:0] op_a_reg;
    logic signed [COEFF_BITS-1:0]  op_b_reg;
    tag_t                          tag1_reg;
    tag_t                          tag2_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [MIX_W-1:0]       mid_acc_reg;
    logic signed [MIX_W-1:0]       side_acc_reg;
    logic signed [MIX_W-1:0]       sh_acc_reg;
    logic signed [FIR_W-1:0]       fir_acc_reg;
    logic signed [SUM_W-1:0]       side_tot_reg;
    logic                          m_valid_reg;
    uhj_out_t                      m_data_reg;

    logic                          s_fire;
    logic                          out_free;
    logic                          mix_last;
    logic signed [SAMPLE_BITS-1:0] mix_a;
    logic signed [COEFF_BITS-1:0]  mix_b;
    tag_t                          mix_tag;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [PROD_W-1:0]      product;
    logic [HIST_AW:0]              hist_step;
    logic [HIST_AW-1:0]            hist_addr_step;
    logic [HIST_AW-1:0]            hist_addr_first;

    logic                          hist_wr_en;
    logic [HIST_AW-1:0]            hist_wr_addr;
    logic [SAMPLE_BITS-1:0]        hist_wr_data;
    logic [SAMPLE_BITS-1:0]        hist_rd_data;
    logic                          dly_wr_en;
    logic [DLY_AW-1:0]             dly_wr_addr;
    logic [2*DL_W-1:0]             dly_wr_data;
    logic [2*DL_W-1:0]             dly_rd_data;

    logic signed [MIX_W-1:0]       mid_rnd;
    logic signed [MIX_W-1:0]       side_rnd;
    logic signed [MIX_W-1:0]       sh_rnd;
    logic signed [DL_W-1:0]        mid_new;
    logic signed [DL_W-1:0]        side_new;
    logic signed [SAMPLE_BITS-1:0] shift_new;
    logic signed [DL_W-1:0]        mid_d;
    logic signed [DL_W-1:0]        side_d;
    logic signed [FIR_W-1:0]       fir_rnd;
    logic signed [SUM_W-1:0]       side_tot_next;
    logic signed [SUM_W-1:0]       left_sum;
    logic signed [SUM_W-1:0]       right_sum;
    logic signed [SUM_W-1:0]       left_rnd;
    logic signed [SUM_W-1:0]       right_rnd;
    logic signed [SAMPLE_BITS-1:0] left_sat;
    logic signed [SAMPLE_BITS-1:0] right_sat;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
        input logic signed [SUM_W-1:0] v
    );
        if (v > OUT_MAX) begin
            return OUT_MAX[SAMPLE_BITS-1:0];
        end
        if (v < OUT_MIN) begin
            return OUT_MIN[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Mixing products: the shift signal uses a negated W constant, so every
    // mix is a plain sum of products.
    always_comb begin
        mix_a         = in_reg.w_sample;
        mix_b         = K_MID_W;
        mix_tag       = TAG_MID;
        mix_last      = 1'b0;
        mix_step_next = MIX_MID_X;
        unique case (mix_step_reg)
            MIX_MID_W: begin
                mix_a         = in_reg.w_sample;
                mix_b         = K_MID_W;
                mix_tag       = TAG_MID;
                mix_step_next = MIX_MID_X;
            end
            MIX_MID_X: begin
                mix_a         = in_reg.x_sample;
                mix_b         = K_MID_X;
                mix_tag       = TAG_MID;
                mix_step_next = MIX_SIDE_Y;
            end
            MIX_SIDE_Y: begin
                mix_a         = in_reg.y_sample;
                mix_b         = K_SIDE_Y;
                mix_tag       = TAG_SIDE;
                mix_step_next = MIX_SH_W;
            end
            MIX_SH_W: begin
                mix_a         = in_reg.w_sample;
                mix_b         = K_SH_W_NEG;
                mix_tag       = TAG_SHIFT;
                mix_step_next = MIX_SH_X;
            end
            MIX_SH_X: begin
                mix_a         = in_reg.x_sample;
                mix_b         = K_SH_X;
                mix_tag       = TAG_SHIFT;
                mix_last      = 1'b1;
                mix_step_next = MIX_MID_W;
            end
            default: begin
                mix_last      = 1'b1;
                mix_step_next = MIX_MID_W;
            end
        endcase
    end

    // The FIR takes history samples of odd age 2*TAPS-1 down to 1. The first
    // read is the slot just past the write pointer, then every second slot.
    assign hist_step       = {1'b0, hist_addr_reg} + (HIST_AW + 1)'(2);
    assign hist_addr_step  = (hist_step >= (HIST_AW + 1)'(HIST_DEPTH))
                           ? HIST_AW'(hist_step - (HIST_AW + 1)'(HIST_DEPTH))
                           : HIST_AW'(hist_step);
    assign hist_addr_first = (wp_reg == HIST_AW'(HIST_DEPTH - 1))
                           ? '0 : wp_reg + 1'b1;

    // During the tap loop the sample operand comes straight from the memory.
    assign mul_a   = (tag1_reg == TAG_FIR) ? $signed(hist_rd_data) : op_a_reg;
    assign product = mul_a * op_b_reg;

    // Rounding of the mixes and of the filter sum.
    assign mid_rnd   = (mid_acc_reg + MIX_HALF) >>> FRAC;
    assign side_rnd  = (side_acc_reg + MIX_HALF) >>> FRAC;
    assign sh_rnd    = (sh_acc_reg + MIX_HALF) >>> FRAC;
    assign mid_new   = DL_W'(mid_rnd) + DL_W'(in_reg.direct_left)
                     + DL_W'(in_reg.direct_right);
    assign side_new  = DL_W'(side_rnd) + DL_W'(in_reg.direct_left)
                     - DL_W'(in_reg.direct_right);
    assign shift_new = SAMPLE_BITS'(sh_rnd);

    assign mid_d         = $signed(dly_rd_data[2*DL_W-1:DL_W]);
    assign side_d        = $signed(dly_rd_data[DL_W-1:0]);
    assign fir_rnd       = (fir_acc_reg + FIR_HALF) >>> FIR_SH;
    assign side_tot_next = SUM_W'(side_d) + SUM_W'(fir_rnd);

    // Final halving with rounding half up, then saturation.
    assign left_sum  = SUM_W'(mid_d) + side_tot_reg;
    assign right_sum = SUM_W'(mid_d) - side_tot_reg;
    assign left_rnd  = (left_sum + SUM_W'(1)) >>> 1;
    assign right_rnd = (right_sum + SUM_W'(1)) >>> 1;
    assign left_sat  = sat_out(left_rnd);
    assign right_sat = sat_out(right_rnd);

    // Memory write ports: the clearing sweep, then one write per item.
    always_comb begin
        hist_wr_en   = 1'b0;
        hist_wr_addr = wp_reg;
        hist_wr_data = shift_new;
        dly_wr_en    = 1'b0;
        dly_wr_addr  = p_reg;
        dly_wr_data  = {mid_new, side_new};
        if (state_reg == ST_CLEAR) begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = clr_reg;
            hist_wr_data = '0;
            dly_wr_en    = (clr_reg < HIST_AW'(TAPS));
            dly_wr_addr  = clr_reg[DLY_AW-1:0];
            dly_wr_data  = '0;
        end else if (state_reg == ST_UPDATE) begin
            hist_wr_en = 1'b1;
            dly_wr_en  = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == HIST_AW'(HIST_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (mix_last) begin
                    state_next = ST_FIR;
                end
            end
            ST_FIR: begin
                if (j_reg == DLY_AW'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            mix_step_reg <= MIX_MID_W;
            clr_reg      <= '0;
            p_reg        <= '0;
            wp_reg       <= '0;
            j_reg        <= '0;
            drain_reg    <= 1'b0;
            tag1_reg     <= TAG_NONE;
            tag2_reg     <= TAG_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end

            // Issue stage of the multiplier pipeline.
            if (state_reg == ST_MIX) begin
                op_a_reg     <= mix_a;
                op_b_reg     <= mix_b;
                tag1_reg     <= mix_tag;
                mix_step_reg <= mix_step_next;
                j_reg        <= '0;
            end else if (state_reg == ST_FIR) begin
                op_b_reg      <= coef_rom[j_reg];
                tag1_reg      <= TAG_FIR;
                j_reg         <= j_reg + 1'b1;
                hist_addr_reg <= hist_addr_step;
                drain_reg     <= 1'b0;
            end else begin
                tag1_reg <= TAG_NONE;
            end

            // Product register and accumulation.
            prod_reg <= product;
            tag2_reg <= tag1_reg;
            case (tag2_reg)
                TAG_MID:   mid_acc_reg  <= mid_acc_reg + MIX_W'(prod_reg);
                TAG_SIDE:  side_acc_reg <= side_acc_reg + MIX_W'(prod_reg);
                TAG_SHIFT: sh_acc_reg   <= sh_acc_reg + MIX_W'(prod_reg);
                TAG_FIR:   fir_acc_reg  <= fir_acc_reg + FIR_W'(prod_reg >>> FIR_DROP);
                default: ;
            endcase

            if (s_fire) begin
                in_reg        <= s_data;
                mix_step_reg  <= MIX_MID_W;
                hist_addr_reg <= hist_addr_first;
                mid_acc_reg   <= '0;
                side_acc_reg  <= '0;
                sh_acc_reg    <= '0;
                fir_acc_reg   <= '0;
            end

            if (state_reg == ST_DRAIN) begin
                drain_reg <= 1'b1;
            end

            // Both delay lines and the history advance by one item.
            if (state_reg == ST_UPDATE) begin
                side_tot_reg <= side_tot_next;
                p_reg        <= (p_reg == DLY_AW'(TAPS - 1)) ? '0 : p_reg + 1'b1;
                wp_reg       <= (wp_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end

            if (state_reg == ST_OUT && out_free) begin
                m_data_reg.left_out  <= left_sat;
                m_data_reg.right_out <= right_sat;
                m_valid_reg          <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Mid and side delay lines share one memory, one word per item slot.
    uhj_ram #(
        .WIDTH (2 * DL_W),
        .DEPTH (TAPS)
    ) u_dly_ram (
        .aclk    (aclk),
        .wr_en   (dly_wr_en),
        .wr_addr (dly_wr_addr),
        .wr_data (dly_wr_data),
        .rd_en   (s_fire),
        .rd_addr (p_reg),
        .rd_data (dly_rd_data)
    );

    // History of the shift signal, a ring of 2*TAPS samples.
    uhj_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (hist_wr_data),
        .rd_en   (state_reg == ST_FIR),
        .rd_addr (hist_addr_reg),
        .rd_data (hist_rd_data)
    );

endmodule

`default_nettype wire

// ===== dv/uhj_encode_checker.sv =====
`timescale 1ns / 100ps

// Scoreboard for the UHJ encoder: predicts each left/right pair from the
// accepted input transfers and compares it with the output transfers.
module uhj_encode_checker
    import uhj_pkg::*;
#(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire uhj_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire uhj_out_t m_data,
    output int unsigned   mismatch_count,
    output int unsigned   pending_results
);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam int     FRAC_BITS    = COEFF_BITS - 1;
    localparam int     GRID_SHIFT   = 32 - COEFF_BITS;
    localparam int     PRODUCT_DROP = 8;
    localparam int     HISTORY_LEN  = 2 * TAPS - 1;
    localparam longint GRID_HALF    = longint'(1) <<< (GRID_SHIFT - 1);
    localparam longint MIX_MID_W    = (longint'(2017974493) + GRID_HALF) >>> GRID_SHIFT;
    localparam longint MIX_MID_X    = (longint'(398517130) + GRID_HALF) >>> GRID_SHIFT;
    localparam longint MIX_SIDE_Y   = (longint'(1407571593) + GRID_HALF) >>> GRID_SHIFT;
    localparam longint MIX_SHIFT_W  = (longint'(734482572) + GRID_HALF) >>> GRID_SHIFT;
    localparam longint MIX_SHIFT_X  = (longint'(1094916872) + GRID_HALF) >>> GRID_SHIFT;
    localparam longint SAMPLE_HI    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_LO    = -SAMPLE_HI - 1;
    localparam logic [63:0] ANGLE_ONE = 64'd1 << 30;
    localparam logic [63:0] ANGLE_PI  = 64'd3373259426;

    longint      phase_coef [TAPS];
    longint      mid_ring   [TAPS];
    longint      side_ring  [TAPS];
    longint      shift_taps [HISTORY_LEN];
    int          ring_ptr;
    uhj_out_t    expected_pairs [$];
    int unsigned fails;

    // Tap j of the +90 degree phase shifter, -cot(pi*m/(2*TAPS))/TAPS with
    // m = TAPS-1-2j, from a Q30 Taylor sine and cosine.
    function automatic longint phase_tap(input int j);
        int          m;
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term_s;
        logic [63:0] term_c;
        logic [63:0] sin_q;
        logic [63:0] cos_q;
        logic [63:0] den;
        logic [63:0] mag;
        longint      sum_s;
        longint      sum_c;
        m = TAPS - 1 - 2 * j;
        if (m % 2 == 0) begin
            return 0;
        end
        ang    = (ANGLE_PI * 64'((m < 0) ? -m : m)) / 64'(2 * TAPS);
        ang_sq = (ang * ang) >> 30;
        term_s = ang;
        term_c = ANGLE_ONE;
        sum_s  = longint'(ang);
        sum_c  = longint'(ANGLE_ONE);
        for (int k = 1; k <= 15; k++) begin
            term_c = ((term_c * ang_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
            term_s = ((term_s * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum_c -= longint'(term_c);
                sum_s -= longint'(term_s);
            end else begin
                sum_c += longint'(term_c);
                sum_s += longint'(term_s);
            end
        end
        sin_q = (sum_s > 0) ? 64'(sum_s) : 64'd0;
        cos_q = (sum_c > 0) ? 64'(sum_c) : 64'd0;
        den   = 64'(TAPS) * sin_q;
        mag   = (den != 0) ? ((cos_q << FRAC_BITS) + den / 2) / den : 64'd0;
        return (m > 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint round_grid(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic sample_t clamp_sample(input longint v);
        if (v > SAMPLE_HI) begin
            return sample_t'(SAMPLE_HI);
        end
        if (v < SAMPLE_LO) begin
            return sample_t'(SAMPLE_LO);
        end
        return sample_t'(v);
    endfunction

    // Advances the encoder state by one input transfer and returns the pair
    // that this transfer releases.
    function automatic uhj_out_t encode_sample(input uhj_in_t item);
        longint   w;
        longint   x;
        longint   y;
        longint   dl;
        longint   dr;
        longint   mid_old;
        longint   side_old;
        longint   shift_now;
        longint   acc;
        longint   side;
        uhj_out_t pair;
        w  = longint'($signed(item.w_sample));
        x  = longint'($signed(item.x_sample));
        y  = longint'($signed(item.y_sample));
        dl = longint'($signed(item.direct_left));
        dr = longint'($signed(item.direct_right));

        mid_old  = mid_ring[ring_ptr];
        side_old = side_ring[ring_ptr];
        mid_ring[ring_ptr]  = round_grid(MIX_MID_W * w + MIX_MID_X * x, FRAC_BITS) + dl + dr;
        side_ring[ring_ptr] = round_grid(MIX_SIDE_Y * y, FRAC_BITS) + dl - dr;
        ring_ptr = (ring_ptr + 1 >= TAPS) ? 0 : ring_ptr + 1;
        shift_now = round_grid(MIX_SHIFT_X * x - MIX_SHIFT_W * w, FRAC_BITS);

        // The filter sees the history before this sample enters it.
        acc = 0;
        for (int j = 0; j < TAPS; j++) begin
            acc += (phase_coef[j] * shift_taps[HISTORY_LEN - 1 - 2 * j]) >>> PRODUCT_DROP;
        end
        for (int k = HISTORY_LEN - 1; k > 0; k--) begin
            shift_taps[k] = shift_taps[k - 1];
        end
        shift_taps[0] = shift_now;

        side = side_old + round_grid(acc, FRAC_BITS - PRODUCT_DROP);
        pair.left_out  = clamp_sample(round_grid(mid_old + side, 1));
        pair.right_out = clamp_sample(round_grid(mid_old - side, 1));
        return pair;
    endfunction

    task automatic check_field(input string field, input sample_t want, input sample_t got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial begin
        for (int j = 0; j < TAPS; j++) begin
            phase_coef[j] = phase_tap(j);
        end
    end

    always @(posedge aclk) begin
        uhj_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) begin
                mid_ring[i]  = 0;
                side_ring[i] = 0;
            end
            for (int i = 0; i < HISTORY_LEN; i++) begin
                shift_taps[i] = 0;
            end
            ring_ptr = 0;
            fails    = 0;
            expected_pairs.delete();
        end else begin
            // A result always belongs to an earlier input, so it is checked
            // before this edge's input is predicted.
            if (m_valid && m_ready) begin
                if (expected_pairs.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: expected none, actual left %0d right %0d",
                             $time, m_data.left_out, m_data.right_out);
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("left_out", want.left_out, m_data.left_out);
                    check_field("right_out", want.right_out, m_data.right_out);
                end
            end
            if (s_valid && s_ready) begin
                expected_pairs.push_back(encode_sample(s_data));
            end
        end
        mismatch_count  <= fails;
        pending_results <= expected_pairs.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Top of the encoder testbench. It drives the input channel, plays the
// receiver on the output channel, and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module testbench;
    import uhj_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Kinds of random traffic. Each segment of the random part keeps one kind
    // for a few dozen samples so that the delay lines and the filter history
    // fill with coherent material.
    typedef enum int {
        MODE_FULL,
        MODE_EXTREME,
        MODE_QUIET,
        MODE_LOUD
    } stim_mode_t;

    localparam int      TAPS         = TAPS_DEFAULT;
    localparam int      RANDOM_ITEMS = 1130;
    localparam int      CALM_ITEMS   = 120;
    localparam int      STALL_LIMIT  = 4000;
    localparam sample_t SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    uhj_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    uhj_out_t    m_data;
    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned stall_cycles = 0;
    // Set for the last part of the run: no idling on either side.
    bit          calm = 1'b0;

    uhj_two_channel_encoder #(
        .TAPS(TAPS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    uhj_encode_checker #(
        .TAPS(TAPS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The watchdog counts cycles in which neither channel completes a
    // transfer. The longest legal quiet stretch is the memory sweep after
    // reset or one item's processing plus a stall on each side, both far below
    // the limit.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // Receiver. It stalls in bursts of random length between ready stretches
    // of random length, now and then a long one with no stall at all. Since
    // each item runs through the whole tap loop, the stalls land on every
    // phase of the block's work, including while a result waits in the output
    // register and the next item is already in flight.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 1) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(200, 600)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 60)) @(posedge aclk);
            end
        end
    end

    function automatic uhj_in_t make_item(input sample_t w, input sample_t x, input sample_t y,
                                          input sample_t dl, input sample_t dr);
        uhj_in_t item;
        item.w_sample     = w;
        item.x_sample     = x;
        item.y_sample     = y;
        item.direct_left  = dl;
        item.direct_right = dr;
        return item;
    endfunction

    // Loud samples sit close to one rail, chosen per field and per segment,
    // so that mid or side stays large long enough to saturate the outputs
    // once it comes out of the delay line.
    function automatic sample_t draw_sample(input stim_mode_t mode, input bit upper);
        case (mode)
            MODE_FULL: begin
                return sample_t'($urandom());
            end
            MODE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    3:       return '1;
                    default: return sample_t'(1);
                endcase
            end
            MODE_QUIET: begin
                return sample_t'(int'($urandom_range(0, 8191)) - 4096);
            end
            default: begin
                if (upper) begin
                    return SAMPLE_MAX - sample_t'($urandom_range(0, 1 << 18));
                end
                return SAMPLE_MIN + sample_t'($urandom_range(0, 1 << 18));
            end
        endcase
    endfunction

    // Offers one item and holds it until the block takes it. Returns right
    // after the edge of the transfer, so the caller either offers the next
    // item or lowers valid in that same step.
    task automatic send_item(input uhj_in_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sender idle burst. Half of the bursts start only once the block shows
    // that it can take an item, so the gap also covers the moment at which
    // the block would otherwise start on the next sample.
    task automatic sender_idle();
        s_valid <= 1'b0;
        if ($urandom_range(0, 1) == 0) begin
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        repeat ($urandom_range(1, 17)) @(posedge aclk);
    endtask

    // Holds the sender off until every predicted result has been received.
    // The first edge lets the checker count the transfer just made.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    initial begin
        uhj_in_t    corner_items [$];
        stim_mode_t mode;
        int         seg_left;
        bit         idle_on;
        logic [4:0] loud_sign;

        // Synchronous reset, once. The block then clears its memories on its own
        // while s_ready stays low.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: silence, every field alone at either rail, all
        // fields at one rail together (pushes mid past full scale), direct
        // left and right in opposition (pushes side past full scale), and a
        // few bit patterns.
        corner_items.push_back(make_item('0, '0, '0, '0, '0));
        corner_items.push_back(make_item(SAMPLE_MAX, '0, '0, '0, '0));
        corner_items.push_back(make_item('0, SAMPLE_MAX, '0, '0, '0));
        corner_items.push_back(make_item('0, '0, SAMPLE_MAX, '0, '0));
        corner_items.push_back(make_item('0, '0, '0, SAMPLE_MAX, '0));
        corner_items.push_back(make_item('0, '0, '0, '0, SAMPLE_MAX));
        corner_items.push_back(make_item(SAMPLE_MIN, '0, '0, '0, '0));
        corner_items.push_back(make_item('0, SAMPLE_MIN, '0, '0, '0));
        corner_items.push_back(make_item('0, '0, SAMPLE_MIN, '0, '0));
        corner_items.push_back(make_item('0, '0, '0, SAMPLE_MIN, '0));
        corner_items.push_back(make_item('0, '0, '0, '0, SAMPLE_MIN));
        corner_items.push_back(make_item(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                         SAMPLE_MAX, SAMPLE_MAX));
        corner_items.push_back(make_item(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                                         SAMPLE_MIN, SAMPLE_MIN));
        corner_items.push_back(make_item(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
                                         SAMPLE_MAX, SAMPLE_MIN));
        corner_items.push_back(make_item(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                                         SAMPLE_MIN, SAMPLE_MAX));
        corner_items.push_back(make_item('1, '1, '1, '1, '1));
        corner_items.push_back(make_item(sample_t'(1), sample_t'(1), sample_t'(1),
                                         sample_t'(1), sample_t'(1)));
        corner_items.push_back(make_item(24'h555555, 24'haaaaaa, 24'h555555,
                                         24'haaaaaa, 24'h555555));
        corner_items.push_back(make_item(24'haaaaaa, 24'h555555, 24'haaaaaa,
                                         24'h555555, 24'haaaaaa));
        foreach (corner_items[i]) begin
            send_item(corner_items[i]);
            if ($urandom_range(0, 1) == 0) begin
                sender_idle();
            end
        end
        drain_results();

        // Random part, in segments of one traffic kind each. Once the calm
        // tail begins, both sides run flat out.
        seg_left = 0;
        mode     = MODE_FULL;
        idle_on  = 1'b1;
        loud_sign = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (seg_left == 0) begin
                case ($urandom_range(0, 19) / 5)
                    0:       mode = MODE_FULL;
                    1:       mode = MODE_LOUD;
                    2:       mode = ($urandom_range(0, 1) == 0) ? MODE_QUIET : MODE_EXTREME;
                    default: mode = MODE_FULL;
                endcase
                seg_left  = $urandom_range(16, 64);
                idle_on   = ($urandom_range(0, 3) != 0);
                loud_sign = 5'($urandom());
            end
            seg_left--;
            send_item(make_item(draw_sample(mode, loud_sign[0]),
                                draw_sample(mode, loud_sign[1]),
                                draw_sample(mode, loud_sign[2]),
                                draw_sample(mode, loud_sign[3]),
                                draw_sample(mode, loud_sign[4])));
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end else if (!calm && idle_on && $urandom_range(0, 2) == 0) begin
                sender_idle();
            end
        end
        s_valid <= 1'b0;

        // Wait for the last result, then long enough for one more item's
        // latency so that any stray result would still be caught.
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (TAPS + 20) @(posedge aclk);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
